// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion forms shared by the decimator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmmd_pkg
// Widths, codes and shared types of the polyline min/max decimator.
// ----------------------------------------------------------------------------
package pmmd_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int STEP_WIDTH     = 23;
	localparam int CFG_IDX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH = 23;
	localparam int CMP_WIDTH      = (COORD_WIDTH + 1 > STEP_WIDTH) ? COORD_WIDTH + 1 : STEP_WIDTH;
	localparam int FIFO_DEPTH     = 2;
	localparam int PTR_WIDTH      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_WIDTH      = $clog2(FIFO_DEPTH + 1);

	localparam logic [STEP_WIDTH-1:0] LINE_STEP_RESET = STEP_WIDTH'(128);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_LINE_STEP   = 2'd0,
		REG_DIRECT_MODE = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		SEG_CONNECT = 1'b0,
		SEG_EXTENT  = 1'b1
	} seg_kind_t;

	typedef struct packed {
		coord_t    x0;
		coord_t    y0;
		coord_t    x1;
		coord_t    y1;
		seg_kind_t kind;
		logic      last;
	} seg_t;

	typedef struct packed {
		logic      valid;
		seg_t      seg;
	} seg_wr_t;

	typedef struct packed {
		logic [STEP_WIDTH-1:0] line_step;
		logic                  direct_mode;
	} cfg_t;

endpackage

// ===== hw/rtl/pmmd_if.sv =====
// ----------------------------------------------------------------------------
// pmmd_if
// Valid/ready channels of the decimator: points in, segments out, config.
// ----------------------------------------------------------------------------
interface pmmd_point_if import pmmd_pkg::*;;
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	logic   first_point;

	modport source (output valid, point_x, point_y, first_point, input ready);
	modport sink   (input valid, point_x, point_y, first_point, output ready);
endinterface

interface pmmd_seg_if import pmmd_pkg::*;;
	logic   valid;
	logic   ready;
	coord_t seg_x0;
	coord_t seg_y0;
	coord_t seg_x1;
	coord_t seg_y1;
	logic   seg_kind;
	logic   seg_last;

	modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, seg_kind, seg_last,
		input ready);
	modport sink   (input valid, seg_x0, seg_y0, seg_x1, seg_y1, seg_kind, seg_last,
		output ready);
endinterface

interface pmmd_cfg_if import pmmd_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [CFG_IDX_WIDTH-1:0]  index;
	logic [CFG_DATA_WIDTH-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pmmd_core.sv =====
// ----------------------------------------------------------------------------
// pmmd_core
// Input register, range state and segment decision for one point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmmd_core import pmmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	pmmd_point_if.sink       points,
	input  cfg_t             cfg,
	output seg_wr_t          wr,
	input  logic             wr_ready
);

	logic   s1_vld_q;
	coord_t s1_x_q;
	coord_t s1_y_q;
	logic   s1_first_q;
	logic   phase_q;

	coord_t range_start_q;
	coord_t range_min_q;
	coord_t range_max_q;
	coord_t prev_x_q;
	coord_t prev_y_q;
	logic   have_point_q;

	logic signed [COORD_WIDTH:0] diff;
	logic [COORD_WIDTH:0]        x_span;
	logic                        in_range;
	logic                        is_start;
	logic                        emits;
	logic                        need_ext;
	logic                        done;
	logic                        ext_fire;
	logic                        accept;

	always_comb begin
		diff     = {s1_x_q[COORD_WIDTH-1], s1_x_q}
			- {range_start_q[COORD_WIDTH-1], range_start_q};
		x_span   = diff[COORD_WIDTH] ? $unsigned(-diff) : $unsigned(diff);
		in_range = CMP_WIDTH'(x_span) < CMP_WIDTH'(cfg.line_step);
		is_start = s1_first_q || !have_point_q;
		emits    = !is_start && (cfg.direct_mode || !in_range);
		need_ext = emits && !cfg.direct_mode && (range_min_q != range_max_q) && !phase_q;
		done     = s1_vld_q && (!emits || (wr_ready && !need_ext));
		ext_fire = s1_vld_q && need_ext && wr_ready;
		accept   = points.valid && points.ready;
	end

	assign points.ready = !s1_vld_q || done;

	always_comb begin
		wr.valid = s1_vld_q && emits;
		if (need_ext) begin
			wr.seg.x0   = range_start_q;
			wr.seg.y0   = range_min_q;
			wr.seg.x1   = range_start_q;
			wr.seg.y1   = range_max_q;
			wr.seg.kind = SEG_EXTENT;
			wr.seg.last = 1'b0;
		end else begin
			wr.seg.x0   = prev_x_q;
			wr.seg.y0   = prev_y_q;
			wr.seg.x1   = s1_x_q;
			wr.seg.y1   = s1_y_q;
			wr.seg.kind = SEG_CONNECT;
			wr.seg.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (accept) begin
				s1_vld_q <= 1'b1;
			end else if (done) begin
				s1_vld_q <= 1'b0;
			end
			if (done) begin
				phase_q <= 1'b0;
			end else if (ext_fire) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_x_q     <= points.point_x;
			s1_y_q     <= points.point_y;
			s1_first_q <= points.first_point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q <= '0;
			range_min_q   <= '0;
			range_max_q   <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			have_point_q  <= 1'b0;
		end else if (done) begin
			prev_x_q     <= s1_x_q;
			prev_y_q     <= s1_y_q;
			have_point_q <= 1'b1;
			if (is_start || cfg.direct_mode || !in_range) begin
				range_start_q <= s1_x_q;
				range_min_q   <= s1_y_q;
				range_max_q   <= s1_y_q;
			end else begin
				if (s1_y_q > range_max_q) begin
					range_max_q <= s1_y_q;
				end
				if (s1_y_q < range_min_q) begin
					range_min_q <= s1_y_q;
				end
			end
		end
	end

	`ASSERT_IMPL(a_phase_needs_item, clk, arst_n, phase_q, s1_vld_q, "extent phase with no held point")
	`ASSERT_IMPL(a_range_ordered, clk, arst_n, have_point_q, range_min_q <= range_max_q, "range min above max")
	`ASSERT_NEXT(a_extent_sets_phase, clk, arst_n, ext_fire, phase_q && s1_vld_q, "extent sent but point lost")

endmodule

// ===== hw/rtl/pmmd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// pmmd_out_fifo
// Small segment queue that decouples the decision logic from the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmmd_out_fifo import pmmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  seg_wr_t     wr,
	output logic        wr_ready,
	pmmd_seg_if.source  segs
);

	seg_t                 mem_q [FIFO_DEPTH];
	logic [PTR_WIDTH-1:0] wr_ptr_q;
	logic [PTR_WIDTH-1:0] rd_ptr_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic                 wr_fire;
	logic                 rd_fire;
	seg_t                 head;

	assign wr_ready = cnt_q != CNT_WIDTH'(FIFO_DEPTH);
	assign wr_fire  = wr.valid && wr_ready;
	assign rd_fire  = segs.valid && segs.ready;
	assign head     = mem_q[rd_ptr_q];

	assign segs.valid    = cnt_q != '0;
	assign segs.seg_x0   = head.x0;
	assign segs.seg_y0   = head.y0;
	assign segs.seg_x1   = head.x1;
	assign segs.seg_y1   = head.y1;
	assign segs.seg_kind = head.kind;
	assign segs.seg_last = head.last;

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= wr.seg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_fire, rd_fire})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_WIDTH'(FIFO_DEPTH), "queue count overrun")
	`ASSERT_NEXT(a_write_lands, clk, arst_n, wr_fire && !rd_fire, cnt_q != '0, "written segment not queued")

endmodule

// ===== hw/rtl/polyline_min_max_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// polyline_min_max_decimator_unit
// Turns mapped plot points into line segments, direct or min/max decimated.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                       transaction
//  points   in   point_x, point_y, first_point                 valid & ready
//  segs     out  seg_x0, seg_y0, seg_x1, seg_y1, seg_kind,     valid & ready
//                seg_last
//  cfg      in   index, data (line_step, direct_mode)          valid & ready
//
//  A point is registered, then decided in the next cycle; one segment enters
//  the two-entry output queue per cycle, so a point that closes a range with
//  a non-zero extent holds the input register until both of its segments
//  are queued. Sustained rate: one point per cycle while the queue has room.
//  Reset clears range state, the queue and the config to its reset values.
//  A full queue stalls the decision stage and, through it, the point input.
//  Config writes are always ready and take effect in the next cycle.
// ----------------------------------------------------------------------------
module polyline_min_max_decimator_unit import pmmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pmmd_point_if.sink  points,
	pmmd_seg_if.source  segs,
	pmmd_cfg_if.sink    cfg
);

	cfg_t    cfg_q;
	seg_wr_t wr;
	logic    wr_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_step   <= LINE_STEP_RESET;
			cfg_q.direct_mode <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_LINE_STEP) begin
				cfg_q.line_step <= cfg.data[STEP_WIDTH-1:0];
			end
			if (cfg.index == REG_DIRECT_MODE) begin
				cfg_q.direct_mode <= cfg.data[0];
			end
		end
	end

	pmmd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.points   (points),
		.cfg      (cfg_q),
		.wr       (wr),
		.wr_ready (wr_ready)
	);

	pmmd_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_ready (wr_ready),
		.segs     (segs)
	);

endmodule

// ===== dv/tb_polyline_min_max_decimator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_min_max_decimator_unit
// Streams plot points through the decimator and checks every segment against
// a behavioral model of the range tracking, in direct and decimating mode,
// across several step settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_polyline_min_max_decimator_unit;
	import pmmd_pkg::*;

	localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic [STEP_WIDTH-1:0] STEP_MAX = '1;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 80;
	localparam int PHASES        = 8;
	localparam int PHASE_POINTS  = 50;

	typedef enum logic {ROW_POINT, ROW_REGS} row_op_t;

	typedef struct {
		row_op_t               op;
		coord_t                x;
		coord_t                y;
		logic                  first;
		logic [STEP_WIDTH-1:0] step;
		logic                  direct;
		bit                    typed;
		int                    typed_n;
		seg_t                  typed_seg;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	pmmd_point_if pt_if();
	pmmd_seg_if   sg_if();
	pmmd_cfg_if   cf_if();

	polyline_min_max_decimator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.points (pt_if),
		.segs   (sg_if),
		.cfg    (cf_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// range tracking state and register copies
	coord_t                rng_x, rng_lo_y, rng_hi_y, last_x, last_y;
	bit                    seen_point;
	logic [STEP_WIDTH-1:0] cfg_step;
	logic                  cfg_direct;

	seg_t       expected_segs[$];
	stim_row_t  plan[$];
	int         failures;
	int         seg_count;
	bit         steady;
	bit         hold_req;

	function automatic void open_range(coord_t x, coord_t y);
		rng_x      = x;
		rng_lo_y   = y;
		rng_hi_y   = y;
		last_x     = x;
		last_y     = y;
		seen_point = 1'b1;
	endfunction

	function automatic int decimate_point(coord_t x, coord_t y, logic first,
		output seg_t extent, output seg_t joint);
		longint gap;
		int n;
		n = 0;
		extent = '0;
		joint = '{x0: last_x, y0: last_y, x1: x, y1: y, kind: SEG_CONNECT, last: 1'b1};
		if (first || !seen_point) begin
			open_range(x, y);
			return 0;
		end
		if (cfg_direct) begin
			open_range(x, y);
			return 1;
		end
		gap = longint'(x) - longint'(rng_x);
		if (gap < 0)
			gap = -gap;
		if (gap < longint'(cfg_step)) begin
			if (y > rng_hi_y)
				rng_hi_y = y;
			if (y < rng_lo_y)
				rng_lo_y = y;
			last_x = x;
			last_y = y;
			return 0;
		end
		if (rng_lo_y != rng_hi_y) begin
			extent = '{x0: rng_x, y0: rng_lo_y, x1: rng_x, y1: rng_hi_y,
				kind: SEG_EXTENT, last: 1'b0};
			n = 1;
		end
		open_range(x, y);
		return n + 1;
	endfunction

	function automatic string fmt_seg(seg_t s);
		return $sformatf("(%0d,%0d)-(%0d,%0d) kind %0d last %0d",
			s.x0, s.y0, s.x1, s.y1, s.kind, s.last);
	endfunction

	function automatic void flag_failure(string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endfunction

	function automatic void add_point(coord_t x, coord_t y, logic first, bit typed = 1'b0,
		int typed_n = 0, seg_t typed_seg = '0);
		stim_row_t row;
		row = '{op: ROW_POINT, x: x, y: y, first: first, step: '0, direct: 1'b0,
			typed: typed, typed_n: typed_n, typed_seg: typed_seg};
		plan.push_back(row);
	endfunction

	function automatic void add_regs(logic [STEP_WIDTH-1:0] step, logic direct);
		stim_row_t row;
		row = '{op: ROW_REGS, x: '0, y: '0, first: 1'b0, step: step, direct: direct,
			typed: 1'b0, typed_n: 0, typed_seg: '0};
		plan.push_back(row);
	endfunction

	task automatic send_point(coord_t x, coord_t y, logic first, bit typed = 1'b0,
		int typed_n = 0, seg_t typed_seg = '0);
		seg_t extent, joint;
		int n;
		if (!steady) begin
			while ($urandom_range(99) < 6) begin
				pt_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		pt_if.valid       <= 1'b1;
		pt_if.point_x     <= x;
		pt_if.point_y     <= y;
		pt_if.first_point <= first;
		do @(posedge clk); while (!pt_if.ready);
		n = decimate_point(x, y, first, extent, joint);
		if (typed) begin
			if (typed_n != 0)
				expected_segs.push_back(typed_seg);
		end else begin
			if (n == 2)
				expected_segs.push_back(extent);
			if (n != 0)
				expected_segs.push_back(joint);
		end
	endtask

	// drop point valid and wait for the segment queue to empty
	task automatic settle();
		pt_if.valid <= 1'b0;
		while (expected_segs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(logic [STEP_WIDTH-1:0] step, logic direct);
		settle();
		cf_if.valid <= 1'b1;
		cf_if.index <= REG_LINE_STEP;
		cf_if.data  <= CFG_DATA_WIDTH'(step);
		do @(posedge clk); while (!cf_if.ready);
		cfg_step = step;
		cf_if.index <= REG_DIRECT_MODE;
		cf_if.data  <= CFG_DATA_WIDTH'(direct);
		do @(posedge clk); while (!cf_if.ready);
		cfg_direct = direct;
		cf_if.valid <= 1'b0;
	endtask

	initial begin : seg_sink
		int hold_left;
		hold_left = 0;
		sg_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				sg_if.ready <= 1'b0;
			end else begin
				sg_if.ready <= steady || ($urandom_range(99) >= 6);
			end
		end
	end

	always @(posedge clk) begin : seg_check
		seg_t got, want;
		if (arst_n && sg_if.valid && sg_if.ready) begin
			got = '{x0: sg_if.seg_x0, y0: sg_if.seg_y0, x1: sg_if.seg_x1,
				y1: sg_if.seg_y1, kind: seg_kind_t'(sg_if.seg_kind), last: sg_if.seg_last};
			if (expected_segs.size() == 0) begin
				flag_failure($sformatf("segment %0d unexpected: %s", seg_count, fmt_seg(got)));
			end else begin
				want = expected_segs.pop_front();
				if (got.x0 !== want.x0 || got.y0 !== want.y0 || got.x1 !== want.x1 ||
					got.y1 !== want.y1 || got.kind !== want.kind || got.last !== want.last)
					flag_failure($sformatf("segment %0d: expected %s, got %s",
						seg_count, fmt_seg(want), fmt_seg(got)));
			end
			seg_count++;
		end
	end

	initial begin : limit
		#2000000;
		$display("tb_polyline_min_max_decimator_unit: errors");
		$finish;
	end

	initial begin : main
		logic [STEP_WIDTH-1:0] step;
		logic                  direct;
		longint                cur_x, cur_y, span, dx;
		coord_t                x, y;
		logic                  first;
		int                    r;

		failures    = 0;
		seg_count   = 0;
		steady      = 1'b0;
		hold_req    = 1'b0;
		arst_n      = 1'b0;
		pt_if.valid       = 1'b0;
		pt_if.point_x     = '0;
		pt_if.point_y     = '0;
		pt_if.first_point = 1'b0;
		cf_if.valid = 1'b0;
		cf_if.index = REG_LINE_STEP;
		cf_if.data  = '0;

		cfg_step   = LINE_STEP_RESET;
		cfg_direct = 1'b0;
		rng_x      = '0;
		rng_lo_y   = '0;
		rng_hi_y   = '0;
		last_x     = '0;
		last_y     = '0;
		seen_point = 1'b0;

		// reset state, decimating with the default step
		add_point(24'sd0, 24'sd0, 1'b0, 1'b1, 0);
		add_point(24'sd100, 24'sd50, 1'b0);
		add_point(24'sd127, -24'sd30, 1'b0);
		add_point(24'sd128, 24'sd7, 1'b0);
		add_point(-24'sd128, 24'sd7, 1'b0);
		add_point(24'sd5, 24'sd5, 1'b1, 1'b1, 0);
		add_point(24'sd130, 24'sd9, 1'b0);
		// direct mode at the coordinate extremes
		add_regs(LINE_STEP_RESET, 1'b1);
		add_point(C_MAX, C_MAX, 1'b1, 1'b1, 0);
		add_point(C_MIN, C_MIN, 1'b0, 1'b1, 1,
			'{x0: C_MAX, y0: C_MAX, x1: C_MIN, y1: C_MIN, kind: SEG_CONNECT, last: 1'b1});
		add_point(C_MAX, C_MIN, 1'b0, 1'b1, 1,
			'{x0: C_MIN, y0: C_MIN, x1: C_MAX, y1: C_MIN, kind: SEG_CONNECT, last: 1'b1});
		add_point(24'sd0, 24'sd0, 1'b1, 1'b1, 0);
		// widest step, back in decimating mode
		add_regs(STEP_MAX, 1'b0);
		add_point(C_MIN, 24'sd0, 1'b0);
		add_point(-24'sd2, C_MAX, 1'b0);
		add_point(C_MAX, C_MIN, 1'b0);
		// narrowest non-zero step
		add_regs(STEP_WIDTH'(1), 1'b0);
		add_point(C_MAX, 24'sd3, 1'b0);
		add_point(C_MAX, -24'sd3, 1'b0);
		add_point(C_MAX - 24'sd1, 24'sd0, 1'b0);
		// zero step closes on every point
		add_regs(STEP_WIDTH'(0), 1'b0);
		add_point(C_MAX - 24'sd1, 24'sd9, 1'b0);
		add_point(C_MAX - 24'sd1, 24'sd9, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].op == ROW_REGS)
				program_regs(plan[i].step, plan[i].direct);
			else
				send_point(plan[i].x, plan[i].y, plan[i].first, plan[i].typed,
					plan[i].typed_n, plan[i].typed_seg);
		end

		for (int p = 0; p < PHASES; p++) begin
			direct = 1'b0;
			case (p)
				0: step = LINE_STEP_RESET;
				1: begin
					step = LINE_STEP_RESET;
					direct = 1'b1;
				end
				2: step = STEP_WIDTH'(1);
				3: step = STEP_MAX;
				4: step = STEP_WIDTH'(0);
				default: begin
					step = ($urandom_range(3) == 0) ? STEP_WIDTH'($urandom)
						: STEP_WIDTH'($urandom_range(2048, 1));
					direct = ($urandom_range(3) == 0);
				end
			endcase
			program_regs(step, direct);
			steady = (p == 5);
			// stall the segment side while points keep coming
			if (p == 1)
				hold_req = 1'b1;
			span = (step == 0) ? 4 : longint'(step);
			cur_x = longint'(coord_t'($urandom));
			cur_y = longint'(coord_t'($urandom));
			for (int i = 0; i < PHASE_POINTS; i++) begin
				r = $urandom_range(99);
				if (r < 8) begin
					x = coord_t'($urandom);
					y = coord_t'($urandom);
					first = 1'($urandom_range(1));
				end else begin
					first = (i == 0) || (r < 12);
					dx = longint'($urandom_range(0, 32'(span + span / 2)));
					if ($urandom_range(4) == 0)
						dx = -dx;
					cur_x += dx;
					if ($urandom_range(2) != 0)
						cur_y += longint'($urandom_range(64)) - 32;
					x = coord_t'(cur_x);
					y = coord_t'(cur_y);
				end
				cur_x = longint'(x);
				cur_y = longint'(y);
				send_point(x, y, first);
			end
		end

		steady = 1'b0;
		settle();
		failures += expected_segs.size();
		if (failures == 0)
			$display("tb_polyline_min_max_decimator_unit: clean");
		else
			$display("tb_polyline_min_max_decimator_unit: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pmmd_pkg.sv
hw/rtl/pmmd_if.sv
hw/rtl/pmmd_core.sv
hw/rtl/pmmd_out_fifo.sv
hw/rtl/polyline_min_max_decimator_unit.sv
dv/tb_polyline_min_max_decimator_unit.sv
